/* hdl/rar_pkg.sv */
// Shared types, widths and command codes for the rational arithmetic reducer.
`timescale 1ns / 1ps

package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int CMD_W             = 2;
    localparam int RAW_NUM_W         = 33;
    localparam int RAW_DEN_W         = 32;
    localparam int RED_NUM_W         = 33;
    localparam int RED_DEN_W         = 32;
    localparam int EXT_W             = 64;
    localparam int OUT_DATA_BITS     = RAW_NUM_W + RAW_DEN_W + RED_NUM_W + RED_DEN_W;
    localparam int OUT_TDATA_W       = ((OUT_DATA_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    // Operand pair routed to the shared multiplier
    typedef enum logic [1:0] {
        MSEL_NONE,
        MSEL_NUM,
        MSEL_CROSS,
        MSEL_DEN
    } msel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_NUM,
        ST_MUL_CROSS,
        ST_MUL_DEN,
        ST_SUM,
        ST_PREP,
        ST_GCD,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic  load;
        msel_t msel;
        logic  sum;
        logic  prep;
        logic  gcd_step;
        logic  div_init;
        logic  div_step;
        logic  out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic gcd_done;
    } dp_stat_t;

endpackage

/* hdl/rational_arith_reduce.sv */
// Top level of the rational fraction arithmetic unit with GCD reduction.
`timescale 1ns / 1ps

// Channel   Direction  Contents (tdata from bit 0 up)                 tuser
// s_        in         cmd, a_num, a_den, b_num, b_den, zero pad      -
// m_        out        raw_num, raw_den, red_num, red_den, zero pad   zero_den_err
//
// One transaction at a time. With W = OPERAND_WIDTH and M = 2*W+1, a transaction
// passes through the three products, the sum and the magnitude step, the binary
// GCD loop, the restoring divider with its M quotient bits, and the load of the
// output register. A zero raw denominator skips the GCD and divider.
// The output register holds a result until m_tready; a new input is taken once
// the previous result has been loaded there. aresetn is synchronous, active low.

module rational_arith_reduce #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // cmd, a_num, a_den, b_num, b_den, zero pad
    input  logic [((rar_pkg::CMD_W + 4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,
    // raw_num, raw_den, red_num, red_den, zero pad
    output logic [rar_pkg::OUT_TDATA_W-1:0] m_tdata,
    // zero_den_err
    output logic m_tuser,
    output logic m_tvalid,
    input  logic m_tready
);

    localparam int RED_LSB = rar_pkg::RAW_NUM_W + rar_pkg::RAW_DEN_W;

    rar_pkg::dp_cmd_t  cmd;
    rar_pkg::dp_stat_t stat;

    // Sequencer: walks each transaction through its steps
    rar_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Arithmetic: one shared multiplier, GCD loop, dividers, output register
    rar_datapath #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .in_tdata  (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_tdata (m_tdata),
        .out_tuser (m_tuser)
    );

    // A zero denominator result carries zero reduced fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[rar_pkg::OUT_TDATA_W-1:RED_LSB] == '0))
        else $error("reduced fields nonzero on zero-denominator result");

    // Never overwrite a result that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while stalled");

    // A result appears only after an output load
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("m_tvalid rose without an output load");

    // No input is taken while the GCD or divider is busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.gcd_step || cmd.div_step || cmd.div_init) |-> !s_tready)
        else $error("input accepted during reduction");

endmodule

/* hdl/rar_datapath.sv */
// Datapath: shared multiplier, sum, binary GCD and twin restoring dividers.
`timescale 1ns / 1ps

module rar_datapath #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic [((rar_pkg::CMD_W + 4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
    input  rar_pkg::dp_cmd_t                        cmd,
    output rar_pkg::dp_stat_t                       stat,
    output logic [rar_pkg::OUT_TDATA_W-1:0]         out_tdata,
    output logic                                    out_tuser
);

    localparam int W   = OPERAND_WIDTH;
    localparam int PW  = 2 * W;
    localparam int RNW = 2 * W + 1;
    localparam int MW  = RNW;
    localparam int KW  = $clog2(MW + 1);
    localparam int CW  = rar_pkg::CMD_W;

    rar_pkg::op_t           op_reg;
    logic signed [W-1:0]    an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0]   p_num_reg, p_cross_reg, rd_reg;
    logic signed [RNW-1:0]  rn_reg, rn_next;
    logic [MW-1:0]          mn_reg, md_reg, mn_next, md_next;
    logic                   neg_reg;
    logic [MW-1:0]          u_reg, v_reg, u_next, v_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [MW-1:0]          g_reg;
    logic [MW-1:0]          xn_reg, xd_reg, rem_n_reg, rem_d_reg;
    logic [MW-1:0]          xn_next, xd_next, rem_n_next, rem_d_next;
    logic [rar_pkg::OUT_TDATA_W-1:0] out_tdata_reg, out_tdata_next;
    logic                   out_tuser_reg;

    logic signed [W-1:0]    mx, my;
    logic signed [PW-1:0]   prod;

    // Shared multiplier operand selection
    always_comb begin
        case (cmd.msel)
            rar_pkg::MSEL_NUM: begin
                mx = an_reg;
                my = (op_reg == rar_pkg::OP_MUL) ? bn_reg : bd_reg;
            end
            rar_pkg::MSEL_CROSS: begin
                mx = bn_reg;
                my = ad_reg;
            end
            rar_pkg::MSEL_DEN: begin
                mx = ad_reg;
                my = (op_reg == rar_pkg::OP_DIV) ? bn_reg : bd_reg;
            end
            default: begin
                mx = '0;
                my = '0;
            end
        endcase
    end

    assign prod = PW'(mx) * PW'(my);

    // Raw numerator
    always_comb begin
        case (op_reg)
            rar_pkg::OP_ADD: rn_next = RNW'(p_num_reg) + RNW'(p_cross_reg);
            rar_pkg::OP_SUB: rn_next = RNW'(p_num_reg) - RNW'(p_cross_reg);
            default:         rn_next = RNW'(p_num_reg);
        endcase
    end

    // Magnitudes
    assign mn_next = rn_reg[RNW-1] ? MW'(unsigned'(-rn_reg)) : MW'(unsigned'(rn_reg));
    assign md_next = rd_reg[PW-1]  ? MW'(unsigned'(-rd_reg)) : MW'(unsigned'(rd_reg));

    // Binary GCD step: one halving or subtract-and-halve per cycle
    logic [MW:0] diff_uv, diff_vu;
    assign diff_uv = {1'b0, u_reg} - {1'b0, v_reg};
    assign diff_vu = {1'b0, v_reg} - {1'b0, u_reg};

    always_comb begin
        u_next = u_reg;
        v_next = v_reg;
        k_next = k_reg;
        if (!u_reg[0] && !v_reg[0]) begin
            u_next = u_reg >> 1;
            v_next = v_reg >> 1;
            k_next = KW'(k_reg + 1'b1);
        end else if (!u_reg[0]) begin
            u_next = u_reg >> 1;
        end else if (!v_reg[0]) begin
            v_next = v_reg >> 1;
        end else if (!diff_uv[MW]) begin
            u_next = diff_uv[MW:1];
        end else begin
            v_next = diff_vu[MW:1];
        end
    end

    // Restoring division, one quotient bit per cycle for each of the two values
    logic [MW:0] trial_n, trial_d;
    logic        ge_n, ge_d;
    assign trial_n = {rem_n_reg, xn_reg[MW-1]};
    assign trial_d = {rem_d_reg, xd_reg[MW-1]};
    assign ge_n    = trial_n >= {1'b0, g_reg};
    assign ge_d    = trial_d >= {1'b0, g_reg};
    assign rem_n_next = ge_n ? MW'(trial_n - {1'b0, g_reg}) : MW'(trial_n);
    assign rem_d_next = ge_d ? MW'(trial_d - {1'b0, g_reg}) : MW'(trial_d);
    assign xn_next    = {xn_reg[MW-2:0], ge_n};
    assign xd_next    = {xd_reg[MW-2:0], ge_d};

    // Output formatting: wrap or extend to the fixed result widths
    logic signed [MW:0]            qn_signed;
    logic signed [rar_pkg::EXT_W-1:0] raw_num_ext, raw_den_ext, red_num_ext;
    logic [rar_pkg::EXT_W-1:0]     red_den_ext;
    logic [rar_pkg::RED_NUM_W-1:0] red_num_f;
    logic [rar_pkg::RED_DEN_W-1:0] red_den_f;

    assign qn_signed   = neg_reg ? -signed'({1'b0, xn_reg}) : signed'({1'b0, xn_reg});
    assign raw_num_ext = rar_pkg::EXT_W'(rn_reg);
    assign raw_den_ext = rar_pkg::EXT_W'(rd_reg);
    assign red_num_ext = rar_pkg::EXT_W'(qn_signed);
    assign red_den_ext = rar_pkg::EXT_W'(xd_reg);
    assign red_num_f   = stat.den_zero ? '0 : red_num_ext[rar_pkg::RED_NUM_W-1:0];
    assign red_den_f   = stat.den_zero ? '0 : red_den_ext[rar_pkg::RED_DEN_W-1:0];

    assign out_tdata_next = {
        {(rar_pkg::OUT_TDATA_W - rar_pkg::OUT_DATA_BITS){1'b0}},
        red_den_f,
        red_num_f,
        raw_den_ext[rar_pkg::RAW_DEN_W-1:0],
        raw_num_ext[rar_pkg::RAW_NUM_W-1:0]
    };

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= rar_pkg::op_t'(in_tdata[CW-1:0]);
            an_reg <= signed'(in_tdata[CW +: W]);
            ad_reg <= signed'(in_tdata[CW + W +: W]);
            bn_reg <= signed'(in_tdata[CW + 2 * W +: W]);
            bd_reg <= signed'(in_tdata[CW + 3 * W +: W]);
        end
        case (cmd.msel)
            rar_pkg::MSEL_NUM:   p_num_reg   <= prod;
            rar_pkg::MSEL_CROSS: p_cross_reg <= prod;
            rar_pkg::MSEL_DEN:   rd_reg      <= prod;
            default: ;
        endcase
        if (cmd.sum) begin
            rn_reg <= rn_next;
        end
        if (cmd.prep) begin
            mn_reg  <= mn_next;
            md_reg  <= md_next;
            neg_reg <= rn_reg[RNW-1] ^ rd_reg[PW-1];
            u_reg   <= mn_next;
            v_reg   <= md_next;
            k_reg   <= '0;
        end else if (cmd.gcd_step) begin
            u_reg <= u_next;
            v_reg <= v_next;
            k_reg <= k_next;
        end
        if (cmd.div_init) begin
            g_reg     <= MW'(v_reg << k_reg);
            xn_reg    <= mn_reg;
            xd_reg    <= md_reg;
            rem_n_reg <= '0;
            rem_d_reg <= '0;
        end else if (cmd.div_step) begin
            xn_reg    <= xn_next;
            xd_reg    <= xd_next;
            rem_n_reg <= rem_n_next;
            rem_d_reg <= rem_d_next;
        end
        if (cmd.out_load) begin
            out_tdata_reg <= out_tdata_next;
            out_tuser_reg <= stat.den_zero;
        end
    end

    assign stat.den_zero = (rd_reg == '0);
    assign stat.gcd_done = (u_reg == '0);
    assign out_tdata     = out_tdata_reg;
    assign out_tuser     = out_tuser_reg;

endmodule

/* hdl/rar_ctrl.sv */
// Controller: sequences multiply, sum, GCD and divide steps and owns the handshakes.
`timescale 1ns / 1ps

module rar_ctrl #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  rar_pkg::dp_stat_t  stat,
    output rar_pkg::dp_cmd_t   cmd
);

    localparam int MW = 2 * OPERAND_WIDTH + 1;
    localparam int CW = $clog2(MW);

    rar_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rar_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            rar_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = rar_pkg::ST_MUL_NUM;
                end
            end
            rar_pkg::ST_MUL_NUM: begin
                cmd.msel   = rar_pkg::MSEL_NUM;
                state_next = rar_pkg::ST_MUL_CROSS;
            end
            rar_pkg::ST_MUL_CROSS: begin
                cmd.msel   = rar_pkg::MSEL_CROSS;
                state_next = rar_pkg::ST_MUL_DEN;
            end
            rar_pkg::ST_MUL_DEN: begin
                cmd.msel   = rar_pkg::MSEL_DEN;
                state_next = rar_pkg::ST_SUM;
            end
            rar_pkg::ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = rar_pkg::ST_PREP;
            end
            rar_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = stat.den_zero ? rar_pkg::ST_FINISH : rar_pkg::ST_GCD;
            end
            rar_pkg::ST_GCD: begin
                if (stat.gcd_done) begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = rar_pkg::ST_DIV;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            rar_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CW'(MW - 1)) begin
                    state_next = rar_pkg::ST_FINISH;
                end else begin
                    cnt_next = CW'(cnt_reg + 1'b1);
                end
            end
            rar_pkg::ST_FINISH: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = rar_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rar_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

/* sim/fraction_checker.sv */
// Result checker for the rational fraction arithmetic unit: predicts and compares.
`timescale 1ns / 1ps

module fraction_checker #(
    parameter int OPW  = rar_pkg::OPERAND_WIDTH_DEF,
    parameter int IN_W = ((rar_pkg::CMD_W + 4 * OPW + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [IN_W-1:0]                 s_tdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rar_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    output int                              mismatch_count,
    output int                              outstanding,
    output int                              results_seen,
    output int                              zero_den_seen
);

    localparam int RAW_DEN_LO = rar_pkg::RAW_NUM_W;
    localparam int RED_NUM_LO = RAW_DEN_LO + rar_pkg::RAW_DEN_W;
    localparam int RED_DEN_LO = RED_NUM_LO + rar_pkg::RED_NUM_W;

    typedef struct packed {
        logic [rar_pkg::RAW_NUM_W-1:0] raw_num;
        logic [rar_pkg::RAW_DEN_W-1:0] raw_den;
        logic [rar_pkg::RED_NUM_W-1:0] red_num;
        logic [rar_pkg::RED_DEN_W-1:0] red_den;
        logic                          zero_den_err;
    } fraction_t;

    fraction_t pending_fractions[$];
    fraction_t want;
    fraction_t got;
    int        bad_count  = 0;
    int        seen_count = 0;
    int        zero_count = 0;

    // Cross-multiply, then reduce by the Euclidean GCD of the magnitudes.
    function automatic fraction_t reduce_fraction(input logic [IN_W-1:0] word);
        rar_pkg::op_t      op;
        longint            an, ad, bn, bd, n, d;
        longint unsigned   mn, md, x, y, t, qn, qd, sn;
        fraction_t         r;
        op = rar_pkg::op_t'(word[1:0]);
        an = longint'($signed(word[rar_pkg::CMD_W +: OPW]));
        ad = longint'($signed(word[rar_pkg::CMD_W + OPW +: OPW]));
        bn = longint'($signed(word[rar_pkg::CMD_W + 2 * OPW +: OPW]));
        bd = longint'($signed(word[rar_pkg::CMD_W + 3 * OPW +: OPW]));
        case (op)
            rar_pkg::OP_ADD: begin
                n = an * bd + bn * ad;
                d = ad * bd;
            end
            rar_pkg::OP_SUB: begin
                n = an * bd - bn * ad;
                d = ad * bd;
            end
            rar_pkg::OP_MUL: begin
                n = an * bn;
                d = ad * bd;
            end
            default: begin
                n = an * bd;
                d = ad * bn;
            end
        endcase
        r.raw_num = n[rar_pkg::RAW_NUM_W-1:0];
        r.raw_den = d[rar_pkg::RAW_DEN_W-1:0];
        if (d == 0) begin
            r.red_num      = '0;
            r.red_den      = '0;
            r.zero_den_err = 1'b1;
        end else begin
            mn = (n < 0) ? -n : n;
            md = (d < 0) ? -d : d;
            x  = mn;
            y  = md;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            qn = mn / x;
            qd = md / x;
            sn = ((n < 0) != (d < 0)) ? -qn : qn;
            r.red_num      = sn[rar_pkg::RED_NUM_W-1:0];
            r.red_den      = qd[rar_pkg::RED_DEN_W-1:0];
            r.zero_den_err = 1'b0;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            pending_fractions.delete();
        end else begin
            // Check the result side first; a transaction accepted at this edge
            // cannot have produced a result at the same edge.
            if (m_tvalid && m_tready) begin
                got.raw_num      = m_tdata[0 +: rar_pkg::RAW_NUM_W];
                got.raw_den      = m_tdata[RAW_DEN_LO +: rar_pkg::RAW_DEN_W];
                got.red_num      = m_tdata[RED_NUM_LO +: rar_pkg::RED_NUM_W];
                got.red_den      = m_tdata[RED_DEN_LO +: rar_pkg::RED_DEN_W];
                got.zero_den_err = m_tuser;
                seen_count++;
                if (got.zero_den_err === 1'b1) zero_count++;
                if (pending_fractions.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: result with nothing expected: raw %0d/%0d red %0d/%0d",
                                 $realtime, $signed(got.raw_num), $signed(got.raw_den),
                                 $signed(got.red_num), got.red_den);
                end else begin
                    want = pending_fractions.pop_front();
                    if (got.raw_num !== want.raw_num || got.raw_den !== want.raw_den ||
                        got.red_num !== want.red_num || got.red_den !== want.red_den ||
                        got.zero_den_err !== want.zero_den_err) begin
                        bad_count++;
                        if (bad_count <= 10) begin
                            $display("%0t: mismatch expected raw %0d/%0d red %0d/%0d err %0b",
                                     $realtime, $signed(want.raw_num), $signed(want.raw_den),
                                     $signed(want.red_num), want.red_den, want.zero_den_err);
                            $display("%0t:            actual raw %0d/%0d red %0d/%0d err %0b",
                                     $realtime, $signed(got.raw_num), $signed(got.raw_den),
                                     $signed(got.red_num), got.red_den, got.zero_den_err);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_fractions.push_back(reduce_fraction(s_tdata));
        end
        mismatch_count <= bad_count;
        outstanding    <= pending_fractions.size();
        results_seen   <= seen_count;
        zero_den_seen  <= zero_count;
    end

endmodule

/* sim/testbench.sv */
// Top of the testbench for the rational fraction arithmetic unit: stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int OPW          = rar_pkg::OPERAND_WIDTH_DEF;
    localparam int IN_W         = ((rar_pkg::CMD_W + 4 * OPW + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 400;   // long result-side hold-off
    localparam int DRAIN_CYCLES = 150;   // above the worst-case transaction latency
    localparam int LIMIT        = 400000;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic [IN_W-1:0]                 s_tdata  = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rar_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;

    int mismatch_count;
    int outstanding;
    int results_seen;
    int zero_den_seen;
    int cycles    = 0;
    bit steady    = 1'b0;   // both sides run without gaps while set
    bit hold_req  = 1'b0;   // ask the receiver for one long hold-off
    bit hold_done = 1'b0;

    rational_arith_reduce #(
        .OPERAND_WIDTH(OPW)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    fraction_checker #(
        .OPW (OPW),
        .IN_W(IN_W)
    ) fraction_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .mismatch_count(mismatch_count),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .zero_den_seen (zero_den_seen)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
    end

    // Abort a hung run.
    initial begin
        wait (cycles >= LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one transaction and hold it until the block takes it. An optional
    // gap in front of it drops tvalid first. Operands keep their low OPW bits.
    task automatic send_fraction_op(input rar_pkg::op_t op, input int an, input int ad,
                                    input int bn, input int bd);
        logic [IN_W-1:0] word;
        word = '0;
        word[0 +: rar_pkg::CMD_W]                   = op;
        word[rar_pkg::CMD_W +: OPW]                 = an[OPW-1:0];
        word[rar_pkg::CMD_W + OPW +: OPW]           = ad[OPW-1:0];
        word[rar_pkg::CMD_W + 2 * OPW +: OPW]       = bn[OPW-1:0];
        word[rar_pkg::CMD_W + 3 * OPW +: OPW]       = bd[OPW-1:0];
        if (!steady && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mix full-range values with small and factor-rich ones, so that reduction
    // actually finds common divisors, and with the extremes.
    function automatic logic [OPW-1:0] random_operand();
        logic [OPW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = OPW'($urandom);
            4, 5, 6:    v = OPW'(int'($urandom_range(0, 40)) - 20);
            7: begin
                case ($urandom_range(0, 4))
                    0:       v = {1'b1, {(OPW - 1){1'b0}}};
                    1:       v = {1'b0, {(OPW - 1){1'b1}}};
                    2:       v = '1;
                    3:       v = OPW'(1);
                    default: v = '0;
                endcase
            end
            8:       v = OPW'($urandom_range(1, 15) << $urandom_range(0, 11));
            default: v = OPW'($urandom_range(1, 200) * 12);
        endcase
        if ($urandom_range(0, 3) == 0) v = -v;
        return v;
    endfunction

    // Receiver: random tready, one long hold-off on request, none while steady.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= 37);
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: simple sums, zero numerators of either sign, zero
        // denominators from each operand, and the operand extremes.
        send_fraction_op(rar_pkg::OP_ADD, 1, 2, 1, 3);
        send_fraction_op(rar_pkg::OP_SUB, 1, 2, 1, 2);
        send_fraction_op(rar_pkg::OP_SUB, 3, -4, 3, -4);
        send_fraction_op(rar_pkg::OP_MUL, 0, -5, 7, 3);
        send_fraction_op(rar_pkg::OP_ADD, 1, 0, 1, 3);
        send_fraction_op(rar_pkg::OP_MUL, 5, 7, 3, 0);
        send_fraction_op(rar_pkg::OP_DIV, 5, 7, 0, 3);
        send_fraction_op(rar_pkg::OP_MUL, 0, 0, 0, 0);
        send_fraction_op(rar_pkg::OP_ADD, -32768, -32768, -32768, -32768);
        send_fraction_op(rar_pkg::OP_SUB, 32767, 1, -32768, 1);
        send_fraction_op(rar_pkg::OP_SUB, -32768, 1, 32767, 1);
        send_fraction_op(rar_pkg::OP_MUL, -32768, 32767, -32768, -32768);
        send_fraction_op(rar_pkg::OP_DIV, 32767, -32768, -32768, 32767);
        send_fraction_op(rar_pkg::OP_DIV, -32768, -32768, -32768, -32768);
        send_fraction_op(rar_pkg::OP_ADD, 32767, 32767, 32767, 32767);
        send_fraction_op(rar_pkg::OP_MUL, -1, -1, -1, -1);
        send_fraction_op(rar_pkg::OP_DIV, -1, 1, 1, -1);
        send_fraction_op(rar_pkg::OP_ADD, 6, -4, 9, 6);
        send_fraction_op(rar_pkg::OP_SUB, 21845, -21846, -21846, 21845);
        send_fraction_op(rar_pkg::OP_DIV, 12, -18, -8, 27);

        // Random: request the long hold-off early on, keep offering through
        // it so the block backs up, and run a gap-free stretch later.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 200 && i < 300);
            if (i == 100) hold_req = 1'b1;
            send_fraction_op(rar_pkg::op_t'($urandom_range(0, 3)), int'(random_operand()),
                             int'(random_operand()), int'(random_operand()),
                             int'(random_operand()));
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // Let the checker see the last push, then drain.
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results over add, subtract, multiply and divide, %0d with zero denominator.",
                 results_seen, zero_den_seen);
        $display("Included a %0d-cycle result-side hold-off; %0d mismatches, %0d results missing.",
                 HOLD_CYCLES, mismatch_count, outstanding);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* rational_arith_reduce.f */
hdl/rar_pkg.sv
hdl/rar_datapath.sv
hdl/rar_ctrl.sv
hdl/rational_arith_reduce.sv
sim/fraction_checker.sv
sim/testbench.sv
